[hw/rtl/box_mean_5x5_row_filter_top_assert.svh]
// assertion macros for the box mean row filter
`ifndef BOX_MEAN_5X5_ROW_FILTER_TOP_ASSERT_SVH
`define BOX_MEAN_5X5_ROW_FILTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// checked property, skipped while reset is asserted
`define BM5_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bm5 assertion failed");
// checked property, also active during reset
`define BM5_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bm5 assertion failed");
`else
`define BM5_ASSERT(label, clk, rstn, prop)
`define BM5_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[hw/rtl/bm5_pkg.sv]
package bm5_pkg;

  localparam int PIX_W       = 8;
  localparam int NUM_ROWS    = 5;
  localparam int COLSUM_W    = 11;
  localparam int TOTAL_W     = 13;
  localparam int MEAN_W      = 8;
  localparam int WIN_DEPTH   = 5;
  localparam int SEEN_W      = 2;
  localparam int FLUSH_W     = 2;
  localparam int TDATA_IN_W  = NUM_ROWS * PIX_W;
  localparam int TDATA_OUT_W = MEAN_W;

  // columns seen in the row, saturating
  localparam logic [SEEN_W-1:0] SEEN_ZERO = 2'd0;
  localparam logic [SEEN_W-1:0] SEEN_TWO  = 2'd2;
  localparam logic [SEEN_W-1:0] SEEN_MAX  = 2'd3;

  // right border flush steps remaining
  localparam logic [FLUSH_W-1:0] FLUSH_IDLE  = 2'd0;
  localparam logic [FLUSH_W-1:0] FLUSH_LAST  = 2'd1;
  localparam logic [FLUSH_W-1:0] FLUSH_START = 2'd2;

  // divide by 25: t * 5243 >> 17 is exact for t < 8192
  localparam int              RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_25 = 13'd5243;
  localparam int              RECIP_SHIFT = 17;

  typedef struct packed {
    logic [COLSUM_W-1:0] colsum;
    logic                last;
  } col_item_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic              row_end;
  } result_t;

  typedef struct packed {
    logic load;       // result written to the output register this cycle
    logic row_end;    // that result closes the row
    logic consume;    // input register item taken this cycle
    logic flushing;   // right border flush in progress
    logic row_start;  // next column starts a new row
  } win_stat_t;

  function automatic logic [MEAN_W-1:0] div25(input logic [TOTAL_W-1:0] t);
    logic [TOTAL_W+RECIP_W-1:0] p;
    p = {{RECIP_W{1'b0}}, t} * {{TOTAL_W{1'b0}}, RECIP_25};
    return p[RECIP_SHIFT +: MEAN_W];
  endfunction

endpackage

[hw/rtl/bm5_in_stage.sv]
module bm5_in_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bm5_pkg::TDATA_IN_W-1:0]  in_pix,
  input  logic                            in_last,
  input  logic                            consume,
  output logic                            item_valid,
  output bm5_pkg::col_item_t              item
);
  import bm5_pkg::*;

  logic      valid_r;
  col_item_t item_r;
  col_item_t item_nxt;

  // column sum of the five vertical pixels
  always_comb begin
    item_nxt.colsum = '0;
    for (int i = 0; i < NUM_ROWS; i++) begin
      item_nxt.colsum = item_nxt.colsum
                      + {{(COLSUM_W-PIX_W){1'b0}}, in_pix[i*PIX_W +: PIX_W]};
    end
    item_nxt.last = in_last;
  end

  assign in_ready   = !valid_r || consume;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

[hw/rtl/bm5_window.sv]
module bm5_window (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bm5_pkg::col_item_t   item,
  input  logic                 item_valid,
  input  logic                 slot_free,
  output bm5_pkg::result_t     res,
  output bm5_pkg::win_stat_t   stat
);
  import bm5_pkg::*;

  logic [COLSUM_W-1:0] win_r   [WIN_DEPTH];
  logic [COLSUM_W-1:0] win_nxt [WIN_DEPTH];
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [SEEN_W-1:0]   seen_r, seen_nxt, seen_inc;
  logic [FLUSH_W-1:0]  flush_cnt_r, flush_cnt_nxt;
  logic [COLSUM_W-1:0] flush_s_r, flush_s_nxt;
  logic [COLSUM_W-1:0] s_in;
  logic                flushing, consume, flush_step, fill;
  logic                load, row_end;

  assign flushing   = (flush_cnt_r != FLUSH_IDLE);
  assign consume    = slot_free && item_valid && !flushing;
  assign flush_step = slot_free && flushing;
  assign s_in       = flushing ? flush_s_r : item.colsum;
  assign fill       = !flushing && (seen_r == SEEN_ZERO);
  assign seen_inc   = (seen_r == SEEN_MAX) ? seen_r : seen_r + 1'b1;

  always_comb begin
    win_nxt       = win_r;
    total_nxt     = total_r;
    seen_nxt      = seen_r;
    flush_cnt_nxt = flush_cnt_r;
    flush_s_nxt   = flush_s_r;
    load          = 1'b0;
    row_end       = 1'b0;

    if (consume || flush_step) begin
      if (fill) begin
        // left border: first column fills every slot
        for (int i = 0; i < WIN_DEPTH; i++) begin
          win_nxt[i] = s_in;
        end
        total_nxt = {s_in, 2'b00} + {2'b00, s_in};
      end else begin
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[WIN_DEPTH-1] = s_in;
        total_nxt = total_r - {2'b00, win_r[0]} + {2'b00, s_in};
      end
    end

    if (consume) begin
      seen_nxt = seen_inc;
      load     = (seen_inc == SEEN_MAX);
      if (item.last) begin
        flush_cnt_nxt = FLUSH_START;
        flush_s_nxt   = item.colsum;
      end
    end else if (flush_step) begin
      flush_cnt_nxt = flush_cnt_r - 1'b1;
      if (flush_cnt_r == FLUSH_LAST) begin
        load     = 1'b1;
        row_end  = 1'b1;
        seen_nxt = SEEN_ZERO;
      end else begin
        // first flush step: only rows of two or more columns have this center
        load = (seen_r >= SEEN_TWO);
      end
    end
  end

  assign res.mean       = div25(total_nxt);
  assign res.row_end    = row_end;
  assign stat.load      = load;
  assign stat.row_end   = row_end;
  assign stat.consume   = consume;
  assign stat.flushing  = flushing;
  assign stat.row_start = !flushing && (seen_r == SEEN_ZERO);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= SEEN_ZERO;
      flush_cnt_r <= FLUSH_IDLE;
    end else begin
      seen_r      <= seen_nxt;
      flush_cnt_r <= flush_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r     <= win_nxt;
    total_r   <= total_nxt;
    flush_s_r <= flush_s_nxt;
  end

endmodule

[hw/rtl/box_mean_5x5_row_filter_top.sv]
// 5x5 box mean along one image row with replicate borders. Each input
// transaction is one pixel column (five vertical gray pixels, two rows above
// to two rows below the center row) with tlast on the row's final column.
// Each output transaction is the truncated mean of the 5x5 window around one
// center pixel, tlast on the row's last center. The first two columns of a
// row give no output; after that one output per column, two columns behind;
// the last column gives up to three outputs (fewer on rows of one or two
// columns). Rate: one column per clock while the result slot is free; a last
// column also holds the window unit for two right border flush steps, input
// held meanwhile. Each result passes the input register (column sum) and the
// output register (window update and the reciprocal multiply that divides by
// 25). Row length is not limited.

`include "box_mean_5x5_row_filter_top_assert.svh"

module box_mean_5x5_row_filter_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // pix_up2, pix_up1, pix_mid, pix_dn1, pix_dn2 (8 bits each)
  input  logic [bm5_pkg::TDATA_IN_W-1:0]  in_tdata,
  input  logic                            in_tlast,   // col_last
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // mean_val (8 bits)
  output logic [bm5_pkg::TDATA_OUT_W-1:0] out_tdata,
  output logic                            out_tlast   // row_end
);
  import bm5_pkg::*;

  col_item_t item;
  logic      item_valid;
  result_t   res;
  win_stat_t stat;
  logic      slot_free;

  logic      out_valid_r;
  result_t   out_res_r;

  // input register holds the column sum so the window step starts registered
  bm5_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_pix     (in_tdata),
    .in_last    (in_tlast),
    .consume    (stat.consume),
    .item_valid (item_valid),
    .item       (item)
  );

  // sliding window of column sums, running total and right border flush
  bm5_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (item_valid),
    .slot_free  (slot_free),
    .res        (res),
    .stat       (stat)
  );

  // output register: window advances whenever the result slot frees up
  assign slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.load) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.mean;
  assign out_tlast  = out_res_r.row_end;

  // a new result never overwrites one still waiting
  `BM5_ASSERT(a_load_into_free_slot, clk, rst_n, stat.load |-> (!out_valid_r || out_tready))
  // a last column always starts the right border flush
  `BM5_ASSERT(a_last_starts_flush, clk, rst_n, (stat.consume && item.last) |=> stat.flushing)
  // the row closing result leaves the window ready for a new row
  `BM5_ASSERT(a_row_end_resets, clk, rst_n, (stat.load && stat.row_end) |=> stat.row_start)
  // no item is taken from the input register during the flush
  `BM5_ASSERT(a_no_take_in_flush, clk, rst_n, !(stat.flushing && stat.consume))
  // reset empties the result slot
  `BM5_ASSERT_ALWAYS(a_reset_clears_output, clk, !rst_n |=> !out_tvalid)

endmodule
